/* rtl/qlte_pkg.sv */
// shared types and constants for the q-learning table engine
`timescale 1ns / 1ps

package qlte_pkg;

    localparam int DW  = 32;   // table value width, signed q16.16
    localparam int IW  = 9;    // state index width
    localparam int AXW = 3;    // action field width
    localparam int RW  = 16;   // rate and coefficient width, q0.16
    localparam int CIW = 3;    // config index width
    localparam int CDW = 32;   // config data width

    localparam logic [DW-1:0] INIT_VALUE = 32'h0000_8000;
    localparam logic [31:0]   LFSR_MASK  = 32'hA300_0000;

    localparam logic [6:0] REROLL_PERCENT = 7'd70;
    localparam logic [6:0] REROLL_SCALE   = 7'd100;

    // register reset values
    localparam logic [RW-1:0]  RST_LEARN_RATE    = 16'd9830;
    localparam logic [RW-1:0]  RST_DISCOUNT      = 16'd58982;
    localparam logic [RW-1:0]  RST_EXPLORE_FLOOR = 16'd3277;
    localparam logic [RW-1:0]  RST_EXPLORE_DECAY = 16'd65470;
    localparam logic [RW-1:0]  RST_EXPLORE_START = 16'd26214;
    localparam logic [CDW-1:0] RST_RNG_SEED      = 32'd1;

    // register indexes
    localparam logic [CIW-1:0] REG_LEARN_RATE    = 3'd0;
    localparam logic [CIW-1:0] REG_DISCOUNT      = 3'd1;
    localparam logic [CIW-1:0] REG_EXPLORE_FLOOR = 3'd2;
    localparam logic [CIW-1:0] REG_EXPLORE_DECAY = 3'd3;
    localparam logic [CIW-1:0] REG_EXPLORE_START = 3'd4;
    localparam logic [CIW-1:0] REG_RNG_SEED      = 3'd5;

    typedef struct packed {
        logic load;          // latch a new item
        logic idx_reduce;    // fold state indexes into range
        logic rng_step;      // advance the lfsr by half a draw
        logic explore_test;  // record explore decision
        logic pick_action;   // record a random action
        logic rd_en;         // table read
        logic rd_row_next;   // read from the next-state row
        logic rd_old;        // read the entry being updated
        logic scan;          // fold read data into running maximum
        logic scan_arg;      // keep the argmax as chosen action
        logic mul_g;         // capture old value and discounted maximum
        logic mul_d;         // scaled temporal difference
        logic write_new;     // saturate and write back
        logic decay;         // decay exploration rate, count update
        logic clr_step;      // one entry of the fill sweep
    } t_dp_cmd;

    typedef struct packed {
        logic is_update;
        logic act_ok;
        logic idx_big;
        logic explore_hit;
        logic action_last;
        logic reroll_hit;
        logic clr_last;
    } t_dp_status;

endpackage

/* rtl/q_learning_table_engine.sv */
// top level of the q-learning table engine: tabular q-learning with epsilon-greedy choice.
// After reset the block fills all STATE_COUNT*ACTION_COUNT table entries with 0.5, one entry a
// cycle, and holds o_busy high for those cycles; configuration writes are taken during the fill.
// An item is taken when i_start is high and o_busy low, and its one result appears on the output
// ports with o_done, which is high for exactly one cycle; the receiver cannot stall, so capture it then.
// Table reads go through the single read port and writes through the single write port, one
// entry a cycle. Each random draw steps the lfsr in S_DRAW1 and S_DRAW2 and is decided in
// S_EVAL. A greedy select scans the state's row, the first of equal maxima winning; an
// exploring select draws an action, and a draw of the last action is redrawn, at most
// MAX_REROLLS times, while a redraw test succeeds. An update whose action is out of range
// skips the table; an out-of-range index has STATE_COUNT subtracted until it is in range.
`timescale 1ns / 1ps

module q_learning_table_engine
    import qlte_pkg::*;
#(
    parameter int STATE_COUNT  = 512,
    parameter int ACTION_COUNT = 5,
    parameter int MAX_REROLLS  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_func,
    input  logic [IW-1:0]         i_state_index,
    input  logic [AXW-1:0]        i_action_taken,
    input  logic signed [DW-1:0]  i_reward_value,
    input  logic [IW-1:0]         i_next_state_index,
    output logic                  o_done,
    output logic [AXW-1:0]        o_chosen_action,
    output logic                  o_explored,
    output logic signed [DW-1:0]  o_new_value,
    output logic [31:0]           o_epoch_count,
    input  logic                  i_cfg_we,
    input  logic [CIW-1:0]        i_cfg_idx,
    input  logic [CDW-1:0]        i_cfg_wdata
);

    localparam int CW = $clog2(ACTION_COUNT + 1);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [CW-1:0] col;

    qlte_ctrl #(
        .ACTION_COUNT (ACTION_COUNT),
        .MAX_REROLLS  (MAX_REROLLS),
        .CW           (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_col    (col),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    qlte_datapath #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT),
        .CW           (CW)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_col              (col),
        .o_status           (status),
        .i_func             (i_func),
        .i_state_index      (i_state_index),
        .i_action_taken     (i_action_taken),
        .i_reward_value     (i_reward_value),
        .i_next_state_index (i_next_state_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_chosen_action    (o_chosen_action),
        .o_explored         (o_explored),
        .o_new_value        (o_new_value),
        .o_epoch_count      (o_epoch_count)
    );

endmodule

/* rtl/qlte_datapath.sv */
// datapath of the q-learning table engine: value table, lfsr, arithmetic and registers
`timescale 1ns / 1ps

module qlte_datapath
    import qlte_pkg::*;
#(
    parameter int STATE_COUNT  = 512,
    parameter int ACTION_COUNT = 5,
    parameter int CW           = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [CW-1:0]         i_col,
    output t_dp_status            o_status,
    input  logic                  i_func,
    input  logic [IW-1:0]         i_state_index,
    input  logic [AXW-1:0]        i_action_taken,
    input  logic signed [DW-1:0]  i_reward_value,
    input  logic [IW-1:0]         i_next_state_index,
    input  logic                  i_cfg_we,
    input  logic [CIW-1:0]        i_cfg_idx,
    input  logic [CDW-1:0]        i_cfg_wdata,
    output logic [AXW-1:0]        o_chosen_action,
    output logic                  o_explored,
    output logic signed [DW-1:0]  o_new_value,
    output logic [31:0]           o_epoch_count
);

    localparam int DEPTH = STATE_COUNT * ACTION_COUNT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [34:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_MIN = 35'sh7_8000_0000;

    function automatic logic [31:0] f_lfsr8(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ LFSR_MASK) : (x >> 1);
        end
        return x;
    endfunction

    // configuration
    logic [RW-1:0] r_learn, r_discount, r_floor, r_decay;

    // live state
    logic [RW-1:0] r_rate;
    logic [31:0]   r_lfsr;
    logic [31:0]   r_count;
    logic [AW-1:0] r_clr_addr;

    // item registers
    logic                 r_func;
    logic [IW-1:0]        r_s, r_sn;
    logic [AXW-1:0]       r_act;
    logic signed [DW-1:0] r_rew;

    // working registers
    logic [DW-1:0]        r_mem [DEPTH];
    logic signed [DW-1:0] r_rdata;
    logic [CW-1:0]        r_rd_col;
    logic signed [DW-1:0] r_best;
    logic signed [DW-1:0] r_old;
    logic signed [32:0]   r_g;
    logic signed [33:0]   r_d;

    logic [AXW-1:0]       r_chosen;
    logic                 r_explored;
    logic signed [DW-1:0] r_newv;

    logic                 s_big, sn_big;
    logic [AW-1:0]        base_s, base_sn, old_addr, rd_addr;
    logic [RW-1:0]        u;
    logic [20:0]          act_prod;
    logic [4:0]           act_draw;
    logic [22:0]          rr_prod;
    logic signed [48:0]   g_prod;
    logic signed [33:0]   t_sum;
    logic signed [50:0]   d_prod;
    logic signed [34:0]   nv_wide;
    logic signed [DW-1:0] nv_sat;
    logic [31:0]          dec_prod;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;

    assign s_big  = {4'd0, r_s}  >= 13'(STATE_COUNT);
    assign sn_big = {4'd0, r_sn} >= 13'(STATE_COUNT);

    assign base_s   = AW'(r_s)  * AW'(ACTION_COUNT);
    assign base_sn  = AW'(r_sn) * AW'(ACTION_COUNT);
    assign old_addr = base_s + AW'(r_act);
    assign rd_addr  = i_cmd.rd_old ? old_addr
                    : ((i_cmd.rd_row_next ? base_sn : base_s) + AW'(i_col));

    assign u        = r_lfsr[RW-1:0];
    assign act_prod = 21'(u) * 21'(ACTION_COUNT);
    assign act_draw = act_prod[20:16];
    assign rr_prod  = 23'(u) * 23'(REROLL_SCALE);

    assign g_prod   = 49'(r_best) * 49'($signed({1'b0, r_discount}));
    assign t_sum    = 34'(r_rew) + 34'(r_g) - 34'(r_old);
    assign d_prod   = 51'(t_sum) * 51'($signed({1'b0, r_learn}));
    assign nv_wide  = 35'(r_old) + 35'(r_d);

    always_comb begin
        if (nv_wide > SAT_MAX) begin
            nv_sat = SAT_MAX[DW-1:0];
        end else if (nv_wide < SAT_MIN) begin
            nv_sat = SAT_MIN[DW-1:0];
        end else begin
            nv_sat = nv_wide[DW-1:0];
        end
    end

    assign dec_prod = 32'(r_rate) * 32'(r_decay);

    assign o_status.is_update   = r_func;
    assign o_status.act_ok      = 5'(r_act) < 5'(ACTION_COUNT);
    assign o_status.idx_big     = s_big | sn_big;
    assign o_status.explore_hit = u < r_rate;
    assign o_status.action_last = act_draw == 5'(ACTION_COUNT - 1);
    assign o_status.reroll_hit  = rr_prod[22:16] < REROLL_PERCENT;
    assign o_status.clr_last    = r_clr_addr == AW'(DEPTH - 1);

    // value table, one write and one registered read per cycle
    assign mem_we    = i_cmd.clr_step | i_cmd.write_new;
    assign mem_waddr = i_cmd.clr_step ? r_clr_addr : old_addr;
    assign mem_wdata = i_cmd.clr_step ? INIT_VALUE : nv_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_col <= i_col;
        end
    end

    // configuration and live state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn    <= RST_LEARN_RATE;
            r_discount <= RST_DISCOUNT;
            r_floor    <= RST_EXPLORE_FLOOR;
            r_decay    <= RST_EXPLORE_DECAY;
            r_rate     <= RST_EXPLORE_START;
            r_lfsr     <= RST_RNG_SEED;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LEARN_RATE: begin
                        r_learn <= i_cfg_wdata[RW-1:0];
                    end
                    REG_DISCOUNT: begin
                        r_discount <= i_cfg_wdata[RW-1:0];
                    end
                    REG_EXPLORE_FLOOR: begin
                        r_floor <= i_cfg_wdata[RW-1:0];
                    end
                    REG_EXPLORE_DECAY: begin
                        r_decay <= i_cfg_wdata[RW-1:0];
                    end
                    REG_EXPLORE_START: begin
                        r_rate <= i_cfg_wdata[RW-1:0];
                    end
                    REG_RNG_SEED: begin
                        // a zero seed would lock the lfsr
                        r_lfsr <= (i_cfg_wdata == '0) ? 32'd1 : i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end else begin
                if (i_cmd.rng_step) begin
                    r_lfsr <= f_lfsr8(r_lfsr);
                end
                if (i_cmd.decay) begin
                    if (r_rate > r_floor) begin
                        r_rate <= dec_prod[31:16];
                    end
                    r_count <= r_count + 32'd1;
                end
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_s        <= i_state_index;
            r_act      <= i_action_taken;
            r_rew      <= i_reward_value;
            r_sn       <= i_next_state_index;
            r_chosen   <= '0;
            r_explored <= 1'b0;
            r_newv     <= '0;
        end else begin
            if (i_cmd.idx_reduce) begin
                if (s_big) begin
                    r_s <= r_s - IW'(STATE_COUNT);
                end
                if (sn_big) begin
                    r_sn <= r_sn - IW'(STATE_COUNT);
                end
            end
            if (i_cmd.explore_test) begin
                r_explored <= o_status.explore_hit;
            end
            if (i_cmd.pick_action) begin
                r_chosen <= act_draw[AXW-1:0];
            end
            // first maximum wins: only a strictly larger value replaces it
            if (i_cmd.scan) begin
                if (r_rd_col == '0 || r_rdata > r_best) begin
                    r_best <= r_rdata;
                    if (i_cmd.scan_arg) begin
                        r_chosen <= AXW'(r_rd_col);
                    end
                end
            end
            if (i_cmd.mul_g) begin
                r_old <= r_rdata;
                r_g   <= g_prod[48:16];
            end
            if (i_cmd.mul_d) begin
                r_d <= d_prod[49:16];
            end
            if (i_cmd.write_new) begin
                r_newv <= nv_sat;
            end
        end
    end

    assign o_chosen_action = r_chosen;
    assign o_explored      = r_explored;
    assign o_new_value     = r_newv;
    assign o_epoch_count   = r_count;

endmodule

/* rtl/qlte_ctrl.sv */
// sequencer of the q-learning table engine
`timescale 1ns / 1ps

module qlte_ctrl
    import qlte_pkg::*;
#(
    parameter int ACTION_COUNT = 5,
    parameter int MAX_REROLLS  = 4,
    parameter int CW           = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_dp_status    i_status,
    output t_dp_cmd       o_cmd,
    output logic [CW-1:0] o_col,
    output logic          o_busy,
    output logic          o_done
);

    localparam int RRW = $clog2(MAX_REROLLS + 2);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_DRAW1 = 4'd3;
    localparam logic [3:0] S_DRAW2 = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_OLD   = 4'd7;
    localparam logic [3:0] S_OLDW  = 4'd8;
    localparam logic [3:0] S_MULD  = 4'd9;
    localparam logic [3:0] S_WRITE = 4'd10;
    localparam logic [3:0] S_DECAY = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // what the pending draw is for
    localparam logic [1:0] K_TEST   = 2'd0;
    localparam logic [1:0] K_ACT    = 2'd1;
    localparam logic [1:0] K_REROLL = 2'd2;

    logic [3:0]     r_state, n_state;
    logic [1:0]     r_kind, n_kind;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [RRW-1:0] r_rerolls, n_rerolls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_kind    <= K_TEST;
            r_cnt     <= '0;
            r_rerolls <= '0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_cnt     <= n_cnt;
            r_rerolls <= n_rerolls;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_cnt     = r_cnt;
        n_rerolls = r_rerolls;
        o_cmd     = '0;
        o_col     = r_cnt;

        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.idx_reduce = 1'b1;
                if (!i_status.idx_big) begin
                    n_cnt = '0;
                    if (i_status.is_update) begin
                        n_state = i_status.act_ok ? S_SCAN : S_DECAY;
                    end else begin
                        n_kind    = K_TEST;
                        n_rerolls = '0;
                        n_state   = S_DRAW1;
                    end
                end
            end
            S_DRAW1: begin
                o_cmd.rng_step = 1'b1;
                n_state        = S_DRAW2;
            end
            S_DRAW2: begin
                o_cmd.rng_step = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                case (r_kind)
                    K_TEST: begin
                        o_cmd.explore_test = 1'b1;
                        if (i_status.explore_hit) begin
                            n_kind  = K_ACT;
                            n_state = S_DRAW1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    K_ACT: begin
                        o_cmd.pick_action = 1'b1;
                        if (i_status.action_last && r_rerolls < RRW'(MAX_REROLLS)) begin
                            n_kind  = K_REROLL;
                            n_state = S_DRAW1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    K_REROLL: begin
                        if (i_status.reroll_hit) begin
                            n_kind    = K_ACT;
                            n_rerolls = r_rerolls + RRW'(1);
                            n_state   = S_DRAW1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // read one column a cycle, compare the column read the cycle before
                o_cmd.rd_row_next = i_status.is_update;
                o_cmd.scan_arg    = !i_status.is_update;
                o_cmd.scan        = r_cnt != '0;
                if (r_cnt < CW'(ACTION_COUNT)) begin
                    o_cmd.rd_en = 1'b1;
                    n_cnt       = r_cnt + CW'(1);
                end else begin
                    n_state = i_status.is_update ? S_OLD : S_DONE;
                end
            end
            S_OLD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_old = 1'b1;
                n_state      = S_OLDW;
            end
            S_OLDW: begin
                o_cmd.mul_g = 1'b1;
                n_state     = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_DECAY;
            end
            S_DECAY: begin
                o_cmd.decay = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

endmodule

/* tb/sv/qlte_tb_pkg.sv */
// item operation codes shared by the checker and the stimulus of the q-learning table engine
`timescale 1ns / 1ps

package qlte_tb_pkg;

    localparam logic FUNC_SELECT = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

endpackage

/* tb/sv/qlte_checker.sv */
// checker for the q-learning table engine: tracks table, lfsr and rates, compares every result
`timescale 1ns / 1ps

module qlte_checker
    import qlte_pkg::*, qlte_tb_pkg::*;
#(
    parameter int STATE_COUNT  = 512,
    parameter int ACTION_COUNT = 5,
    parameter int MAX_REROLLS  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_func,
    input  logic [IW-1:0]         i_state_index,
    input  logic [AXW-1:0]        i_action_taken,
    input  logic signed [DW-1:0]  i_reward_value,
    input  logic [IW-1:0]         i_next_state_index,
    input  logic                  i_done,
    input  logic [AXW-1:0]        i_chosen_action,
    input  logic                  i_explored,
    input  logic signed [DW-1:0]  i_new_value,
    input  logic [31:0]           i_epoch_count,
    input  logic                  i_cfg_we,
    input  logic [CIW-1:0]        i_cfg_idx,
    input  logic [CDW-1:0]        i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [AXW-1:0]        action;
        logic                  explored;
        logic signed [DW-1:0]  value;
        logic [31:0]           epochs;
    } t_outcome;

    logic signed [DW-1:0] q_table [STATE_COUNT*ACTION_COUNT];
    logic [RW-1:0]        alpha_q16;
    logic [RW-1:0]        gamma_q16;
    logic [RW-1:0]        eps_floor;
    logic [RW-1:0]        eps_decay;
    logic [RW-1:0]        eps;
    logic [31:0]          updates_done;
    logic [31:0]          lfsr;

    t_outcome pending_outcomes[$];
    int       mismatch_total = 0;
    int       results_seen   = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("%0d ns  mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic logic [RW-1:0] draw_u16();
        repeat (16) lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
        return lfsr[RW-1:0];
    endfunction

    function automatic logic [AXW-1:0] draw_action();
        return AXW'((32'(draw_u16()) * ACTION_COUNT) >> 16);
    endfunction

    function automatic t_outcome choose_action(input logic [IW-1:0] state);
        t_outcome             res;
        int                   row;
        int                   rolls;
        logic signed [DW-1:0] best;
        res  = '0;
        row  = (state % STATE_COUNT) * ACTION_COUNT;
        if (draw_u16() < eps) begin
            res.explored = 1'b1;
            res.action   = draw_action();
            rolls        = 0;
            // a random pick of the last action is redrawn, a bounded number of times
            while (res.action == ACTION_COUNT - 1 && rolls < MAX_REROLLS) begin
                if (((32'(draw_u16()) * REROLL_SCALE) >> 16) >= REROLL_PERCENT)
                    break;
                res.action = draw_action();
                rolls++;
            end
        end else begin
            // greedy: the first of equal maxima wins
            best = q_table[row];
            for (int a = 1; a < ACTION_COUNT; a++) begin
                if (q_table[row+a] > best) begin
                    best       = q_table[row+a];
                    res.action = AXW'(a);
                end
            end
        end
        res.epochs = updates_done;
        return res;
    endfunction

    function automatic t_outcome apply_learning(input logic [IW-1:0] state,
                                                input logic [AXW-1:0] act,
                                                input logic signed [DW-1:0] reward,
                                                input logic [IW-1:0] next_state);
        t_outcome             res;
        int                   row;
        int                   next_row;
        logic signed [DW-1:0] maxq;
        logic signed [DW-1:0] oldq;
        longint               g;
        longint               td;
        longint               nv;
        res = '0;
        if (act < ACTION_COUNT) begin
            row      = (state % STATE_COUNT) * ACTION_COUNT + act;
            next_row = (next_state % STATE_COUNT) * ACTION_COUNT;
            maxq     = q_table[next_row];
            for (int a = 1; a < ACTION_COUNT; a++)
                if (q_table[next_row+a] > maxq)
                    maxq = q_table[next_row+a];
            oldq = q_table[row];
            // arithmetic shifts of the 64-bit products round toward minus infinity
            g  = (longint'(maxq) * longint'(gamma_q16)) >>> 16;
            td = longint'(reward) + g - longint'(oldq);
            nv = longint'(oldq) + ((td * longint'(alpha_q16)) >>> 16);
            if (nv > 64'sh0000_0000_7FFF_FFFF)
                nv = 64'sh0000_0000_7FFF_FFFF;
            if (nv < -64'sh0000_0000_8000_0000)
                nv = -64'sh0000_0000_8000_0000;
            q_table[row] = nv[DW-1:0];
            res.value    = nv[DW-1:0];
        end
        if (eps > eps_floor)
            eps = RW'((32'(eps) * eps_decay) >> 16);
        updates_done = updates_done + 1;
        res.epochs   = updates_done;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (q_table[k])
                q_table[k] = INIT_VALUE;
            alpha_q16    = RST_LEARN_RATE;
            gamma_q16    = RST_DISCOUNT;
            eps_floor    = RST_EXPLORE_FLOOR;
            eps_decay    = RST_EXPLORE_DECAY;
            eps          = RST_EXPLORE_START;
            updates_done = '0;
            lfsr         = RST_RNG_SEED;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LEARN_RATE:    alpha_q16 = i_cfg_wdata[RW-1:0];
                    REG_DISCOUNT:      gamma_q16 = i_cfg_wdata[RW-1:0];
                    REG_EXPLORE_FLOOR: eps_floor = i_cfg_wdata[RW-1:0];
                    REG_EXPLORE_DECAY: eps_decay = i_cfg_wdata[RW-1:0];
                    REG_EXPLORE_START: eps       = i_cfg_wdata[RW-1:0];
                    // a zero seed would lock the lfsr, so it loads as one
                    REG_RNG_SEED:      lfsr = (i_cfg_wdata == '0) ? 32'd1 : i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_done) begin
                results_seen++;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %0d came with no item outstanding",
                                              results_seen));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_chosen_action !== want.action)
                        report_mismatch($sformatf("result %0d chosen_action %0d, expected %0d",
                                                  results_seen, i_chosen_action, want.action));
                    if (i_explored !== want.explored)
                        report_mismatch($sformatf("result %0d explored %0b, expected %0b",
                                                  results_seen, i_explored, want.explored));
                    if (i_new_value !== want.value)
                        report_mismatch($sformatf("result %0d new_value %0d, expected %0d",
                                                  results_seen, i_new_value, want.value));
                    if (i_epoch_count !== want.epochs)
                        report_mismatch($sformatf("result %0d epoch_count %0d, expected %0d",
                                                  results_seen, i_epoch_count, want.epochs));
                end
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_UPDATE)
                    pending_outcomes.push_back(apply_learning(i_state_index, i_action_taken,
                                                              i_reward_value,
                                                              i_next_state_index));
                else
                    pending_outcomes.push_back(choose_action(i_state_index));
            end
        end
        o_pending <= pending_outcomes.size();
    end

endmodule

/* tb/sv/tb_q_learning_table_engine.sv */
// stimulus and verdict for the q-learning table engine, with the checker beside the block
`timescale 1ns / 1ps

module tb_q_learning_table_engine;

    import qlte_pkg::*;
    import qlte_tb_pkg::*;

    localparam int STATE_COUNT  = 512;
    localparam int ACTION_COUNT = 5;
    localparam int MAX_REROLLS  = 4;

    localparam int STALL_LIMIT = 20000;   // covers the fill sweep after reset several times
    localparam int TAIL_CYCLES = 50;
    localparam int PHASE_ITEMS = 400;
    localparam int PHASES      = 5;

    // indexes past the last register, which the block ignores
    localparam logic [CIW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CIW-1:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_start            = 1'b0;
    logic                  i_func             = FUNC_SELECT;
    logic [IW-1:0]         i_state_index      = '0;
    logic [AXW-1:0]        i_action_taken     = '0;
    logic signed [DW-1:0]  i_reward_value     = '0;
    logic [IW-1:0]         i_next_state_index = '0;
    logic                  i_cfg_we           = 1'b0;
    logic [CIW-1:0]        i_cfg_idx          = '0;
    logic [CDW-1:0]        i_cfg_wdata        = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [AXW-1:0]        o_chosen_action;
    logic                  o_explored;
    logic signed [DW-1:0]  o_new_value;
    logic [31:0]           o_epoch_count;

    int mismatches;
    int pending_results;
    int idle_cycles    = 0;
    int selects_sent   = 0;
    int updates_sent   = 0;
    int stray_actions  = 0;
    int settings_count = 0;
    bit steady         = 1'b0;

    always #5 i_clk = ~i_clk;

    q_learning_table_engine #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT),
        .MAX_REROLLS  (MAX_REROLLS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_func             (i_func),
        .i_state_index      (i_state_index),
        .i_action_taken     (i_action_taken),
        .i_reward_value     (i_reward_value),
        .i_next_state_index (i_next_state_index),
        .o_done             (o_done),
        .o_chosen_action    (o_chosen_action),
        .o_explored         (o_explored),
        .o_new_value        (o_new_value),
        .o_epoch_count      (o_epoch_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    qlte_checker #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT),
        .MAX_REROLLS  (MAX_REROLLS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_busy             (o_busy),
        .i_func             (i_func),
        .i_state_index      (i_state_index),
        .i_action_taken     (i_action_taken),
        .i_reward_value     (i_reward_value),
        .i_next_state_index (i_next_state_index),
        .i_done             (o_done),
        .i_chosen_action    (o_chosen_action),
        .i_explored         (o_explored),
        .i_new_value        (o_new_value),
        .i_epoch_count      (o_epoch_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_mismatches       (mismatches),
        .o_pending          (pending_results)
    );

    // no progress means neither an item nor a result moved
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: %0d cycles without progress", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic put_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // 16-bit registers get random upper bits, which the block drops
    task automatic load_settings(input logic [RW-1:0] alpha, input logic [RW-1:0] gamma,
                                 input logic [RW-1:0] floor_rate, input logic [RW-1:0] decay,
                                 input logic [RW-1:0] start_rate, input logic [CDW-1:0] seed);
        put_reg(REG_SPARE_LO, $urandom);
        put_reg(REG_LEARN_RATE, {16'($urandom), alpha});
        put_reg(REG_DISCOUNT, {16'($urandom), gamma});
        put_reg(REG_EXPLORE_FLOOR, {16'($urandom), floor_rate});
        put_reg(REG_EXPLORE_DECAY, {16'($urandom), decay});
        put_reg(REG_EXPLORE_START, {16'($urandom), start_rate});
        put_reg(REG_RNG_SEED, seed);
        put_reg(REG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0 || o_busy)
            @(posedge i_clk);
    endtask

    task automatic drive_item(input logic func, input logic [IW-1:0] state,
                              input logic [AXW-1:0] act, input logic signed [DW-1:0] reward,
                              input logic [IW-1:0] next_state);
        int roll;
        int gap;
        i_start            <= 1'b1;
        i_func             <= func;
        i_state_index      <= state;
        i_action_taken     <= act;
        i_reward_value     <= reward;
        i_next_state_index <= next_state;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        if (func == FUNC_UPDATE) begin
            updates_sent++;
            if (act >= ACTION_COUNT)
                stray_actions++;
        end else begin
            selects_sent++;
        end
        roll = $urandom_range(0, 999);
        if (steady)               gap = 0;
        else if (roll < 450)      gap = 0;
        else if (roll < 850)      gap = $urandom_range(1, 4);
        else if (roll < 970)      gap = $urandom_range(5, 15);
        else                      gap = $urandom_range(20, 80);
        // now and then hold the next item back until the block has answered everything
        if (roll >= 990) begin
            wait_idle();
        end else if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // mostly a few busy rows so values build up, sometimes the top rows or anywhere
    function automatic logic [IW-1:0] pick_state();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 8)
            return IW'($urandom_range(0, 7));
        else if (roll < 9)
            return IW'($urandom_range(STATE_COUNT - 8, STATE_COUNT - 1));
        return IW'($urandom);
    endfunction

    task automatic drive_random_item(input int select_pct);
        logic                 func;
        logic [AXW-1:0]       act;
        logic signed [DW-1:0] reward;
        int                   roll;
        func = ($urandom_range(0, 99) < select_pct) ? FUNC_SELECT : FUNC_UPDATE;
        if ($urandom_range(0, 19) == 0)
            act = AXW'($urandom_range(ACTION_COUNT, (1 << AXW) - 1));
        else
            act = AXW'($urandom_range(0, ACTION_COUNT - 1));
        roll = $urandom_range(0, 9);
        if (roll < 5)
            reward = DW'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
        else if (roll < 8)
            reward = DW'($urandom);
        else begin
            case ($urandom_range(0, 3))
                0:       reward = 32'sh7FFF_FFFF;
                1:       reward = 32'sh8000_0000;
                2:       reward = '0;
                default: reward = -32'sd1;
            endcase
        end
        drive_item(func, pick_state(), act, reward, pick_state());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // greedy only, full-scale learning and discount, zero seed
        load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 32'h0000_0000);
        drive_item(FUNC_SELECT, 0, 0, 0, 0);
        drive_item(FUNC_UPDATE, 511, 4, 32'sh7FFF_FFFF, 511);
        drive_item(FUNC_UPDATE, 511, 4, 32'sh7FFF_FFFF, 511);   // saturates high
        drive_item(FUNC_SELECT, 511, 0, 0, 0);
        for (int a = 0; a < ACTION_COUNT; a++)
            drive_item(FUNC_UPDATE, 3, AXW'(a), 32'sh8000_0000, 3);
        drive_item(FUNC_UPDATE, 3, 2, 32'sh8000_0000, 3);       // whole row negative, saturates low
        drive_item(FUNC_SELECT, 3, 0, 0, 0);
        drive_item(FUNC_UPDATE, 0, 5, 32'sh0001_0000, 0);
        drive_item(FUNC_UPDATE, 0, 7, 32'sh7FFF_FFFF, 511);
        drive_item(FUNC_UPDATE, 1, 0, 0, 0);
        wait_idle();

        // always exploring, no learning, rate pinned at its floor
        load_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (8)
            drive_item(FUNC_SELECT, IW'($urandom), 0, 0, 0);
        drive_item(FUNC_UPDATE, 511, 4, 32'sh8000_0000, 3);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            int select_pct;
            select_pct = 50;
            steady     = (p == 1);
            case (p)
                0: load_settings(RST_LEARN_RATE, RST_DISCOUNT, RST_EXPLORE_FLOOR,
                                 RST_EXPLORE_DECAY, RST_EXPLORE_START, $urandom);
                1: begin
                    load_settings(16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  $urandom);
                    select_pct = 80;
                end
                2: begin
                    // rate collapses to zero at the first update
                    load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'($urandom),
                                  $urandom);
                    select_pct = 40;
                end
                3: load_settings(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, $urandom);
                default: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom), $urandom);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_random_item(select_pct);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d selects and %0d updates (%0d with an action out of range)",
                 selects_sent, updates_sent, stray_actions);
        $display("across %0d register settings, gaps and drains between items",
                 settings_count);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
